@@ src/wels_pkg.sv @@
// ----------------------------------------------------------------------------
// wels_pkg
// Shared types and constants for the wave equation leapfrog stepper.
// ----------------------------------------------------------------------------
package wels_pkg;

  localparam int CELLS = 2048;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W = ADDR_W + 1;

  localparam int CMD_W = 2;
  localparam int IDX_W = 11;
  localparam int SAMPLE_W = 32;
  localparam int GAIN_W = 32;
  localparam int REGION_W = 12;
  localparam int GAIN_FRAC = 30;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 2'd0,
    CMD_STEP = 2'd1,
    CMD_READ = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    REG_NORMAL_GAIN  = 2'd0,
    REG_SLOW_GAIN    = 2'd1,
    REG_SLOW_START   = 2'd2,
    REG_SLOW_END     = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SWEEP = 2'd1,
    ST_DRAIN = 2'd2
  } state_e;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic [ADDR_W-1:0] addr;
  } cell_tag_t;

endpackage

@@ src/wels_in_if.sv @@
// ----------------------------------------------------------------------------
// wels_in_if
// Command channel of the stepper: load, step or read one cell.
// ----------------------------------------------------------------------------
interface wels_in_if
  import wels_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           command;
  logic [IDX_W-1:0]           cell_index;
  logic signed [SAMPLE_W-1:0] sample_value;

  modport source (output valid, output command, output cell_index, output sample_value,
                  input ready);
  modport sink (input valid, input command, input cell_index, input sample_value,
                output ready);
endinterface

@@ src/wels_out_if.sv @@
// ----------------------------------------------------------------------------
// wels_out_if
// Result channel of the stepper: one sample returned by a read command.
// ----------------------------------------------------------------------------
interface wels_out_if
  import wels_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] read_value;
  logic [IDX_W-1:0]           read_index;

  modport source (output valid, output read_value, output read_index, input ready);
  modport sink (input valid, input read_value, input read_index, output ready);
endinterface

@@ src/wels_ram.sv @@
// ----------------------------------------------------------------------------
// wels_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module wels_ram #(
  parameter int Width = 32,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/wave_equation_leapfrog_stepper_core.sv @@
// ----------------------------------------------------------------------------
// wave_equation_leapfrog_stepper_core
// Leapfrog time step of the 1-D wave equation over two field memories.
// ----------------------------------------------------------------------------
//   Channel     Direction  Handshake               Content
//   in_chan_i   in         valid/ready             command, cell_index, sample_value
//   out_chan_o  out        valid/ready             read_value, read_index
//   APB         in/out     psel/penable, pready=1  four configuration registers
//
// A load is written when it is accepted; a read passes the registered memory read and then the output register.
// During a step one cell per cycle is read from the current field memory, and the new cell
// passes the arrival, laplacian, product and sum registers and is written over the previous field.
// After a step the two memories swap roles; the fields are not copied.
// Reset returns control and configuration to their reset values; field memories are not cleared.
// A read command waits while an earlier read is pending or the output register holds a result not yet taken.
// ----------------------------------------------------------------------------
module wave_equation_leapfrog_stepper_core
  import wels_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  wels_in_if.sink           in_chan_i,
  wels_out_if.source        out_chan_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(CELLS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
  localparam logic signed [39:0] SAT_MAX = 40'sd2147483647;
  localparam logic signed [39:0] SAT_MIN = -40'sd2147483648;

  // Configuration registers.
  logic [GAIN_W-1:0]   normal_gain_q;
  logic [GAIN_W-1:0]   slow_gain_q;
  logic [REGION_W-1:0] slow_start_q;
  logic [REGION_W-1:0] slow_end_q;
  logic                cfg_we;
  reg_e                cfg_reg;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_reg = reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_gain_q <= 32'd25332749;
      slow_gain_q   <= 32'd24739;
      slow_start_q  <= 12'd896;
      slow_end_q    <= 12'd1024;
    end else if (cfg_we) begin
      case (cfg_reg)
        REG_NORMAL_GAIN: normal_gain_q <= pwdata;
        REG_SLOW_GAIN:   slow_gain_q   <= pwdata;
        REG_SLOW_START:  slow_start_q  <= pwdata[REGION_W-1:0];
        REG_SLOW_END:    slow_end_q    <= pwdata[REGION_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg)
      REG_NORMAL_GAIN: prdata = normal_gain_q;
      REG_SLOW_GAIN:   prdata = slow_gain_q;
      REG_SLOW_START:  prdata = APB_DW'(slow_start_q);
      REG_SLOW_END:    prdata = APB_DW'(slow_end_q);
      default:         prdata = '0;
    endcase
  end

  // Control.
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  sweep_q, sweep_d;
  logic              sel_q, sel_d;
  logic              rd_pend_q;
  logic              rd_inrange_q;
  logic [IDX_W-1:0]  rd_idx_q;
  logic              out_valid_q;
  logic signed [SAMPLE_W-1:0] out_value_q;
  logic [IDX_W-1:0]  out_index_q;

  logic              in_ready;
  logic              issue_en;
  logic              accept;
  logic              in_range;
  logic              load_we;
  logic              read_acc;
  cell_tag_t         s3_q;

  assign accept   = in_chan_i.valid && in_ready;
  assign in_range = 32'(in_chan_i.cell_index) < CELLS;
  assign load_we  = accept && in_chan_i.command == CMD_LOAD && in_range;
  assign read_acc = accept && in_chan_i.command == CMD_READ;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && in_chan_i.command == CMD_STEP) begin
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (sweep_q == LAST_CNT) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (s3_q.valid && s3_q.last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    issue_en = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready = !(in_chan_i.command == CMD_READ &&
                     (rd_pend_q || (out_valid_q && !out_chan_o.ready)));
      end
      ST_SWEEP: issue_en = 1'b1;
      ST_DRAIN: ;
      default: ;
    endcase
  end

  assign in_chan_i.ready = in_ready;
  assign sweep_d = issue_en ? sweep_q + 1'b1 : '0;
  assign sel_d   = (s3_q.valid && s3_q.last) ? !sel_q : sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sweep_q     <= '0;
      sel_q       <= 1'b0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sweep_q   <= sweep_d;
      sel_q     <= sel_d;
      rd_pend_q <= read_acc;
      if (rd_pend_q) begin
        out_valid_q <= 1'b1;
      end else if (out_chan_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Field memories: the one selected by sel_q holds the current field.
  logic [ADDR_W-1:0]   cur_raddr, prv_raddr;
  logic [ADDR_W-1:0]   raddr0, raddr1, waddr;
  logic [SAMPLE_W-1:0] rdata0, rdata1, wdata, step_wdata;
  logic                we0, we1;
  logic signed [SAMPLE_W-1:0] cur_rd, prv_rd;

  assign cur_raddr = issue_en ? ((sweep_q == LAST_CNT) ? LAST_ADDR : sweep_q[ADDR_W-1:0])
                              : ADDR_W'(in_chan_i.cell_index);
  assign prv_raddr = ADDR_W'(sweep_q - 1'b1);
  assign raddr0    = sel_q ? prv_raddr : cur_raddr;
  assign raddr1    = sel_q ? cur_raddr : prv_raddr;
  assign we0       = load_we || (s3_q.valid && sel_q);
  assign we1       = load_we || (s3_q.valid && !sel_q);
  assign waddr     = s3_q.valid ? s3_q.addr : ADDR_W'(in_chan_i.cell_index);
  assign wdata     = s3_q.valid ? step_wdata : in_chan_i.sample_value;
  assign cur_rd    = sel_q ? rdata1 : rdata0;
  assign prv_rd    = sel_q ? rdata0 : rdata1;

  wels_ram #(.Width(SAMPLE_W), .Depth(CELLS)) u_field0 (
    .clk_i   (clk_i),
    .we_i    (we0),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr0),
    .rdata_o (rdata0)
  );

  wels_ram #(.Width(SAMPLE_W), .Depth(CELLS)) u_field1 (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr1),
    .rdata_o (rdata1)
  );

  // Read result.
  always_ff @(posedge clk_i) begin
    if (read_acc) begin
      rd_idx_q     <= in_chan_i.cell_index;
      rd_inrange_q <= in_range;
    end
    if (rd_pend_q) begin
      out_value_q <= rd_inrange_q ? cur_rd : '0;
      out_index_q <= rd_idx_q;
    end
  end

  assign out_chan_o.valid      = out_valid_q;
  assign out_chan_o.read_value = out_value_q;
  assign out_chan_o.read_index = out_index_q;

  // Step pipeline: arrival, laplacian, products, sum, then write back.
  logic                       arr_valid_q;
  logic [CNT_W-1:0]           arr_cnt_q;
  logic signed [SAMPLE_W-1:0] left_q, mid_q, right_v;
  logic                       slow;
  cell_tag_t                  s1_d, s1_q, s2_q;
  logic signed [33:0]         lap_q, c2p1_q, c2p2_q, c2p3_q;
  logic [GAIN_W-1:0]          gain_q;
  logic signed [16:0]         gain_hi, gain_lo;
  logic signed [50:0]         prod_hi_d, prod_lo_d, prod_hi_q, prod_lo_q;
  logic signed [67:0]         sum_d, sum_q;
  logic signed [37:0]         term;
  logic signed [39:0]         total;

  assign right_v     = (arr_cnt_q == LAST_CNT) ? mid_q : cur_rd;
  assign s1_d.valid  = arr_valid_q && arr_cnt_q != '0;
  assign s1_d.last   = arr_cnt_q == LAST_CNT;
  assign s1_d.addr   = ADDR_W'(arr_cnt_q - 1'b1);
  assign slow        = 32'(s1_d.addr) >= 32'(slow_start_q) &&
                       32'(s1_d.addr) < 32'(slow_end_q);
  assign gain_hi     = $signed({1'b0, gain_q[31:16]});
  assign gain_lo     = $signed({1'b0, gain_q[15:0]});
  assign prod_hi_d   = lap_q * gain_hi;
  assign prod_lo_d   = lap_q * gain_lo;
  assign sum_d       = (68'(prod_hi_q) <<< 16) + 68'(prod_lo_q);
  assign term        = 38'(sum_q >>> GAIN_FRAC);
  assign total       = 40'(term) + 40'(c2p3_q);

  always_comb begin
    if (total > SAT_MAX) begin
      step_wdata = 32'h7fff_ffff;
    end else if (total < SAT_MIN) begin
      step_wdata = 32'h8000_0000;
    end else begin
      step_wdata = total[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arr_valid_q <= 1'b0;
      s1_q        <= '0;
      s2_q        <= '0;
      s3_q        <= '0;
    end else begin
      arr_valid_q <= issue_en;
      s1_q        <= s1_d;
      s2_q        <= s1_q;
      s3_q        <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    arr_cnt_q <= sweep_q;
    if (arr_valid_q) begin
      left_q <= (arr_cnt_q == '0) ? cur_rd : mid_q;
      mid_q  <= cur_rd;
    end
    lap_q     <= 34'(left_q) + 34'(right_v) - (34'(mid_q) <<< 1);
    c2p1_q    <= (34'(mid_q) <<< 1) - 34'(prv_rd);
    gain_q    <= slow ? slow_gain_q : normal_gain_q;
    prod_hi_q <= prod_hi_d;
    prod_lo_q <= prod_lo_d;
    c2p2_q    <= c2p1_q;
    sum_q     <= sum_d;
    c2p3_q    <= c2p2_q;
  end

`ifndef SYNTHESIS
  a_out_not_overwritten: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> !out_valid_q)
    else $error("read result arrives while the output register is full");

  a_no_load_during_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_chan_i.ready |-> (state_q == ST_IDLE && !s3_q.valid))
    else $error("input accepted while a step is writing back");

  a_swap_at_step_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sel_q != $past(sel_q)) |-> ($past(state_q) == ST_DRAIN))
    else $error("field memories swapped outside the end of a step");

  a_last_write_ends_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_q.valid && s3_q.last) |=> (state_q == ST_IDLE))
    else $error("step did not finish after its last cell");
`endif

endmodule
